// ===== rtl/euler_rotate_point_3d_defines.svh =====
// ----------------------------------------------------------------------------
// Euler rotation assertion macros
// Shared concurrent checks on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef EULER_ROTATE_POINT_3D_DEFINES_SVH
`define EULER_ROTATE_POINT_3D_DEFINES_SVH

`ifndef SYNTH
// expr must hold at every clock edge
`define ERP_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// ante at one edge implies cons at the next edge
`define ERP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ERP_ASSERT_ALWAYS(lbl, expr, msg)
`define ERP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/erp_pkg.sv =====
// ----------------------------------------------------------------------------
// Euler rotation package
// Fixed-point constants, folded-angle type and series divisors.
// ----------------------------------------------------------------------------
package erp_pkg;

   // angle magnitude after folding into [0, pi/2], Q30
   localparam int MAG_WIDTH   = 31;
   localparam int U2_WIDTH    = 32;
   localparam int SUM_WIDTH   = 33;
   localparam int TERMS       = 8;
   // exact reciprocal division: v < 2^32, divisor < 512
   localparam int RECIP_SHIFT = 41;
   localparam int RECIP_LO    = 21;

   localparam logic [33:0] Q30_PI      = 34'd3373259426;
   localparam logic [33:0] Q30_HALF_PI = 34'd1686629713;
   localparam logic [MAG_WIDTH-1:0] Q30_ONE = 31'd1073741824;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic                 neg_s;
      logic                 neg_c;
      logic [MAG_WIDTH-1:0] mag;
   } erp_fold_type;

   function automatic int sin_div(input int k);
      return (2 * k) * (2 * k + 1);
   endfunction

   function automatic int cos_div(input int k);
      return (2 * k - 1) * (2 * k);
   endfunction

endpackage

// ===== rtl/euler_rotate_point_3d.sv =====
// ----------------------------------------------------------------------------
// Euler rotation of a 3D point
// z-x-z Euler rotation of a Q16.16 point by angles psi, theta, phi (Q3.13).
//
//   channel   ports                         direction
//   request   req_push / req_full + fields  in
//   response  rsp_pop / rsp_empty + fields  out
//
// One request per cycle sustained while responses are popped; each request
// gives one response. The front register loads at the accepting edge, then
// writes the four-entry queue that feeds the 32-stage datapath (24 of them
// are the eight pipelined Taylor terms).
// A waiting response freezes the datapath; the queue then absorbs requests.
// Reset is synchronous and clears only control state.
// ----------------------------------------------------------------------------
module euler_rotate_point_3d #(
   parameter int COORD_WIDTH    = 32,
   parameter int ANGLE_WIDTH    = 16,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_psi,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_theta,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_phi,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_x,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_y,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_z
);
   import erp_pkg::*;

   localparam int QW = 3 * COORD_WIDTH + 3 * $bits(erp_fold_type);

   logic                       q_wr, q_full, q_rd, q_empty;
   logic [3*COORD_WIDTH-1:0]   wr_coords, rd_coords;
   erp_fold_type [2:0]         wr_fold, rd_fold;
   logic [QW-1:0]              rd_data;

   erp_front #(
      .COORD_WIDTH(COORD_WIDTH),
      .ANGLE_WIDTH(ANGLE_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_angle_psi   (req_angle_psi),
      .req_angle_theta (req_angle_theta),
      .req_angle_phi   (req_angle_phi),
      .q_full          (q_full),
      .q_wr            (q_wr),
      .q_coords        (wr_coords),
      .q_fold          (wr_fold)
   );

   erp_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_wr),
      .wr_data ({wr_fold, wr_coords}),
      .full    (q_full),
      .rd      (q_rd),
      .rd_data (rd_data),
      .empty   (q_empty)
   );

   assign rd_coords = rd_data[3*COORD_WIDTH-1:0];
   assign rd_fold   = rd_data[QW-1:3*COORD_WIDTH];

   erp_back #(
      .COORD_WIDTH   (COORD_WIDTH),
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_rd      (q_rd),
      .q_coords  (rd_coords),
      .q_fold    (rd_fold),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_rot_x (rsp_rot_x),
      .rsp_rot_y (rsp_rot_y),
      .rsp_rot_z (rsp_rot_z)
   );

endmodule

// ===== rtl/erp_front.sv =====
// ----------------------------------------------------------------------------
// Euler rotation front end
// Registers a request and folds each angle into [0, pi/2] with sign flags.
// ----------------------------------------------------------------------------
module erp_front #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_psi,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_theta,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_phi,
   input  logic                          q_full,
   output logic                          q_wr,
   output logic [3*COORD_WIDTH-1:0]      q_coords,
   output erp_pkg::erp_fold_type [2:0]   q_fold
);
   import erp_pkg::*;

   logic                          valid_ff, valid_in;
   logic                          accept;
   logic signed [COORD_WIDTH-1:0] pos_ff [3];
   logic signed [ANGLE_WIDTH-1:0] ang_ff [3];

   function automatic erp_fold_type fold_angle(input logic signed [ANGLE_WIDTH-1:0] a);
      logic signed [34:0] x;
      logic [33:0]        m;
      logic signed [34:0] d;
      erp_fold_type       f;
      x       = 35'(a) <<< (33 - ANGLE_WIDTH);
      f.neg_s = x[34];
      f.neg_c = 1'b0;
      m       = x[34] ? 34'(-x) : 34'(x);
      f.mag   = m[MAG_WIDTH-1:0];
      if (m > Q30_HALF_PI) begin
         d       = $signed({1'b0, Q30_PI}) - $signed({1'b0, m});
         f.neg_c = 1'b1;
         if (d < 0) begin
            d       = -d;
            f.neg_s = !f.neg_s;
         end
         f.mag = d[MAG_WIDTH-1:0];
      end
      return f;
   endfunction

   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_wr     = valid_ff && !q_full;
   // hold the request while the queue is full
   assign valid_in = accept || (valid_ff && q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
         ang_ff[0] <= req_angle_psi;
         ang_ff[1] <= req_angle_theta;
         ang_ff[2] <= req_angle_phi;
      end
   end

   assign q_coords = {pos_ff[2], pos_ff[1], pos_ff[0]};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_fold[i] = fold_angle(ang_ff[i]);
      end
   end

endmodule

// ===== rtl/erp_queue.sv =====
// ----------------------------------------------------------------------------
// Euler rotation request queue
// Short first-in first-out buffer between the front end and the datapath.
// ----------------------------------------------------------------------------
`include "euler_rotate_point_3d_defines.svh"

module erp_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   import erp_pkg::*;

   localparam logic [QUEUE_PTR_W:0] DEPTH_CNT = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

   logic [WIDTH-1:0]       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   cnt_ff, cnt_in;

   assign full    = (cnt_ff == DEPTH_CNT);
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign cnt_in    = cnt_ff + (QUEUE_PTR_W + 1)'(wr) - (QUEUE_PTR_W + 1)'(rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `ERP_ASSERT_ALWAYS(a_q_cnt_range, cnt_ff <= DEPTH_CNT, "queue count beyond depth")
   `ERP_ASSERT_ALWAYS(a_q_no_overflow, !(wr && full), "write into full queue")
   `ERP_ASSERT_ALWAYS(a_q_no_underflow, !(rd && empty), "read from empty queue")

endmodule

// ===== rtl/erp_sincos.sv =====
// ----------------------------------------------------------------------------
// Euler rotation sine/cosine unit
// Pipelined nine-term Taylor series on a folded angle, three stages per term.
// ----------------------------------------------------------------------------
module erp_sincos #(
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic                             clock,
   input  logic                             adv,
   input  erp_pkg::erp_fold_type            fold,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_q,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_q
);
   import erp_pkg::*;

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int SH = 30 - TRIG_FRAC_BITS;

   logic [2*MAG_WIDTH-1:0]       sq_in;
   logic [MAG_WIDTH-1:0]         ts_ff   [0:TERMS];
   logic [MAG_WIDTH-1:0]         tc_ff   [0:TERMS];
   logic [U2_WIDTH-1:0]          u2_ff   [0:TERMS];
   logic signed [SUM_WIDTH-1:0]  ssum_ff [0:TERMS];
   logic signed [SUM_WIDTH-1:0]  csum_ff [0:TERMS];
   logic [1:0]                   sg_ff   [0:TERMS];
   logic signed [TW-1:0]         sin_ff, cos_ff;

   function automatic logic signed [TW-1:0] to_trig(input logic signed [SUM_WIDTH-1:0] s,
                                                    input logic neg);
      logic signed [SUM_WIDTH:0] v;
      logic signed [SUM_WIDTH:0] r;
      logic signed [SUM_WIDTH:0] one;
      v   = neg ? -(SUM_WIDTH + 1)'(s) : (SUM_WIDTH + 1)'(s);
      one = $signed((SUM_WIDTH + 1)'(1) << TRIG_FRAC_BITS);
      r   = (v + $signed((SUM_WIDTH + 1)'(1) << (SH - 1))) >>> SH;
      if (r > one) begin
         r = one;
      end
      if (r < -one) begin
         r = -one;
      end
      return TW'(r);
   endfunction

   assign sq_in = fold.mag * fold.mag;

   always_ff @(posedge clock) begin
      if (adv) begin
         u2_ff[0]   <= sq_in[30 +: U2_WIDTH];
         ts_ff[0]   <= fold.mag;
         tc_ff[0]   <= Q30_ONE;
         ssum_ff[0] <= $signed({2'b00, fold.mag});
         csum_ff[0] <= $signed({2'b00, Q30_ONE});
         sg_ff[0]   <= {fold.neg_s, fold.neg_c};
      end
   end

   for (genvar k = 1; k <= TERMS; k++) begin : g_term
      localparam int DS = sin_div(k);
      localparam int DC = cos_div(k);
      localparam logic [63:0] RS = ((64'd1 << RECIP_SHIFT) + 64'(DS - 1)) / 64'(DS);
      localparam logic [63:0] RC = ((64'd1 << RECIP_SHIFT) + 64'(DC - 1)) / 64'(DC);

      logic [MAG_WIDTH+U2_WIDTH-1:0] ms_in, mc_in;
      logic [U2_WIDTH-1:0]           vs_a_ff, vc_a_ff, vs_b_ff, vc_b_ff;
      logic [U2_WIDTH-1:0]           u2_a_ff, u2_b_ff;
      logic signed [SUM_WIDTH-1:0]   ss_a_ff, cs_a_ff, ss_b_ff, cs_b_ff;
      logic [1:0]                    sg_a_ff, sg_b_ff;
      logic [U2_WIDTH+RECIP_LO-1:0]  ps_in, pc_in, ps_b_ff, pc_b_ff;
      logic [U2_WIDTH+RECIP_SHIFT:0] fs_in, fc_in;
      logic [MAG_WIDTH-1:0]          ts_in, tc_in;

      // next term before division: floor(t * u2 / 2^30)
      assign ms_in = ts_ff[k-1] * u2_ff[k-1];
      assign mc_in = tc_ff[k-1] * u2_ff[k-1];
      // reciprocal multiply in two partial products
      assign ps_in = vs_a_ff * RS[RECIP_LO-1:0];
      assign pc_in = vc_a_ff * RC[RECIP_LO-1:0];
      assign fs_in = (U2_WIDTH + RECIP_SHIFT + 1)'(ps_b_ff)
                   + ((U2_WIDTH + RECIP_SHIFT + 1)'(vs_b_ff * RS[RECIP_SHIFT-1:RECIP_LO])
                      << RECIP_LO);
      assign fc_in = (U2_WIDTH + RECIP_SHIFT + 1)'(pc_b_ff)
                   + ((U2_WIDTH + RECIP_SHIFT + 1)'(vc_b_ff * RC[RECIP_SHIFT-1:RECIP_LO])
                      << RECIP_LO);
      assign ts_in = fs_in[RECIP_SHIFT +: MAG_WIDTH];
      assign tc_in = fc_in[RECIP_SHIFT +: MAG_WIDTH];

      always_ff @(posedge clock) begin
         if (adv) begin
            vs_a_ff <= ms_in[30 +: U2_WIDTH];
            vc_a_ff <= mc_in[30 +: U2_WIDTH];
            u2_a_ff <= u2_ff[k-1];
            ss_a_ff <= ssum_ff[k-1];
            cs_a_ff <= csum_ff[k-1];
            sg_a_ff <= sg_ff[k-1];

            ps_b_ff <= ps_in;
            pc_b_ff <= pc_in;
            vs_b_ff <= vs_a_ff;
            vc_b_ff <= vc_a_ff;
            u2_b_ff <= u2_a_ff;
            ss_b_ff <= ss_a_ff;
            cs_b_ff <= cs_a_ff;
            sg_b_ff <= sg_a_ff;

            ts_ff[k] <= ts_in;
            tc_ff[k] <= tc_in;
            u2_ff[k] <= u2_b_ff;
            sg_ff[k] <= sg_b_ff;
            // odd terms subtract, even terms add
            if (k % 2 == 1) begin
               ssum_ff[k] <= ss_b_ff - $signed({2'b00, ts_in});
               csum_ff[k] <= cs_b_ff - $signed({2'b00, tc_in});
            end else begin
               ssum_ff[k] <= ss_b_ff + $signed({2'b00, ts_in});
               csum_ff[k] <= cs_b_ff + $signed({2'b00, tc_in});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff <= to_trig(ssum_ff[TERMS], sg_ff[TERMS][1]);
         cos_ff <= to_trig(csum_ff[TERMS], sg_ff[TERMS][0]);
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

// ===== rtl/erp_back.sv =====
// ----------------------------------------------------------------------------
// Euler rotation datapath
// Sine/cosine of three angles, z-x-z matrix build, matrix-vector product,
// rounding and saturation. One global advance stalls every stage together.
// ----------------------------------------------------------------------------
`include "euler_rotate_point_3d_defines.svh"

module erp_back #(
   parameter int COORD_WIDTH    = 32,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   output logic                          q_rd,
   input  logic [3*COORD_WIDTH-1:0]      q_coords,
   input  erp_pkg::erp_fold_type [2:0]   q_fold,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_x,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_y,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_z
);
   import erp_pkg::*;

   localparam int T      = TRIG_FRAC_BITS;
   localparam int TW     = T + 2;
   localparam int EW     = T + 3;
   localparam int PW     = EW + COORD_WIDTH;
   localparam int SW     = PW + 2;
   localparam int STAGES = 32;
   // stage that holds trig values, entries and the coordinate used by the product
   localparam int ST_TRIG = 26;
   localparam int ST_ENT  = 29;

   // pair products
   localparam int P_CFCP = 0;
   localparam int P_SFSP = 1;
   localparam int P_SFCP = 2;
   localparam int P_CFSP = 3;
   localparam int P_SPST = 4;
   localparam int P_CPST = 5;
   localparam int P_SFST = 6;
   localparam int P_CFST = 7;
   // angle lanes
   localparam int A_PSI   = 0;
   localparam int A_THETA = 1;
   localparam int A_PHI   = 2;

   localparam logic signed [SW-1:0] MAXV = $signed({{(SW-COORD_WIDTH+1){1'b0}},
                                                    {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [SW-1:0] MINV = $signed({{(SW-COORD_WIDTH+1){1'b1}},
                                                    {(COORD_WIDTH-1){1'b0}}});
   localparam logic signed [EW-1:0] ELIM = $signed(EW'(1) << (T + 1));

   logic [STAGES-1:0]             v_ff, v_in;
   logic                          adv;
   erp_fold_type                  fold0_ff [3];
   logic signed [COORD_WIDTH-1:0] coord_ff [0:ST_ENT][3];
   logic signed [TW-1:0]          sn [3];
   logic signed [TW-1:0]          cs [3];
   logic signed [TW-1:0]          pair_ff [8];
   logic signed [TW-1:0]          pair2_ff [8];
   logic signed [TW-1:0]          ct1_ff, ct2_ff;
   logic signed [TW-1:0]          tri_a_ff, tri_b_ff, tri_c_ff, tri_d_ff;
   logic signed [EW-1:0]          e_ff [9];
   logic signed [PW-1:0]          prod_ff [9];
   logic signed [COORD_WIDTH-1:0] rot_ff [3];
   logic signed [COORD_WIDTH-1:0] rot_in [3];

   function automatic logic signed [TW-1:0] mulq(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
      logic signed [2*TW-1:0] pr;
      pr = a * b;
      pr = pr + $signed((2 * TW)'(1) << (T - 1));
      pr = pr >>> T;
      return TW'(pr);
   endfunction

   // advance every stage unless a finished result waits
   assign adv  = !v_ff[STAGES-1] || rsp_pop;
   assign q_rd = adv && !q_empty;
   assign v_in = {v_ff[STAGES-2:0], !q_empty};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            fold0_ff[i]    <= q_fold[i];
            coord_ff[0][i] <= $signed(q_coords[i*COORD_WIDTH +: COORD_WIDTH]);
         end
         for (int s = 1; s <= ST_ENT; s++) begin
            coord_ff[s] <= coord_ff[s-1];
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_angle
      erp_sincos #(
         .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
      ) u_sincos (
         .clock (clock),
         .adv   (adv),
         .fold  (fold0_ff[i]),
         .sin_q (sn[i]),
         .cos_q (cs[i])
      );
   end

   // pairs, then triples with cos theta, then matrix entries, products and the result
   always_ff @(posedge clock) begin
      if (adv) begin
         pair_ff[P_CFCP] <= mulq(cs[A_PHI], cs[A_PSI]);
         pair_ff[P_SFSP] <= mulq(sn[A_PHI], sn[A_PSI]);
         pair_ff[P_SFCP] <= mulq(sn[A_PHI], cs[A_PSI]);
         pair_ff[P_CFSP] <= mulq(cs[A_PHI], sn[A_PSI]);
         pair_ff[P_SPST] <= mulq(sn[A_PSI], sn[A_THETA]);
         pair_ff[P_CPST] <= mulq(cs[A_PSI], sn[A_THETA]);
         pair_ff[P_SFST] <= mulq(sn[A_PHI], sn[A_THETA]);
         pair_ff[P_CFST] <= mulq(cs[A_PHI], sn[A_THETA]);
         ct1_ff          <= cs[A_THETA];

         tri_a_ff <= mulq(pair_ff[P_SFSP], ct1_ff);
         tri_b_ff <= mulq(pair_ff[P_CFSP], ct1_ff);
         tri_c_ff <= mulq(pair_ff[P_SFCP], ct1_ff);
         tri_d_ff <= mulq(pair_ff[P_CFCP], ct1_ff);
         pair2_ff <= pair_ff;
         ct2_ff   <= ct1_ff;

         e_ff[0] <= EW'(pair2_ff[P_CFCP]) - EW'(tri_a_ff);
         e_ff[1] <= -(EW'(pair2_ff[P_SFCP]) + EW'(tri_b_ff));
         e_ff[2] <= EW'(pair2_ff[P_SPST]);
         e_ff[3] <= EW'(pair2_ff[P_CFSP]) + EW'(tri_c_ff);
         e_ff[4] <= EW'(tri_d_ff) - EW'(pair2_ff[P_SFSP]);
         e_ff[5] <= -EW'(pair2_ff[P_CPST]);
         e_ff[6] <= EW'(pair2_ff[P_SFST]);
         e_ff[7] <= EW'(pair2_ff[P_CFST]);
         e_ff[8] <= EW'(ct2_ff);

         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[3*r+c] <= PW'(e_ff[3*r+c]) * PW'(coord_ff[ST_ENT][c]);
            end
         end

         rot_ff <= rot_in;
      end
   end

   // round once, then clamp to the coordinate range
   always_comb begin
      logic signed [SW-1:0] acc;
      logic signed [SW-1:0] r;
      for (int i = 0; i < 3; i++) begin
         acc = SW'(prod_ff[3*i]) + SW'(prod_ff[3*i+1]) + SW'(prod_ff[3*i+2])
             + $signed(SW'(1) << (T - 1));
         r   = acc >>> T;
         if (r > MAXV) begin
            rot_in[i] = MAXV[COORD_WIDTH-1:0];
         end else if (r < MINV) begin
            rot_in[i] = MINV[COORD_WIDTH-1:0];
         end else begin
            rot_in[i] = r[COORD_WIDTH-1:0];
         end
      end
   end

   assign rsp_empty = !v_ff[STAGES-1];
   assign rsp_rot_x = rot_ff[0];
   assign rsp_rot_y = rot_ff[1];
   assign rsp_rot_z = rot_ff[2];

   `ERP_ASSERT_ALWAYS(a_fold_range,
      !v_ff[0] || (fold0_ff[0].mag <= Q30_HALF_PI && fold0_ff[1].mag <= Q30_HALF_PI
                   && fold0_ff[2].mag <= Q30_HALF_PI),
      "folded angle above pi/2")
   `ERP_ASSERT_ALWAYS(a_trig_range,
      !v_ff[ST_TRIG] || (sn[A_THETA] <= $signed(TW'(1) << T)
                         && cs[A_THETA] >= -$signed(TW'(1) << T)),
      "trig value outside unit range")
   `ERP_ASSERT_ALWAYS(a_entry_range,
      !v_ff[ST_ENT] || (e_ff[0] <= ELIM && e_ff[0] >= -ELIM
                        && e_ff[4] <= ELIM && e_ff[4] >= -ELIM),
      "matrix entry out of bound")
   `ERP_ASSERT_NEXT(a_queue_load, q_rd, v_ff[0], "queue read lost")

endmodule
